@@ hw/rtl/pefa_pkg.sv @@
// Package for the pointer event frame assembler: event codes, command
// format passed from the front end to the back end, and shared helpers.
// No dependencies.
`default_nettype none

package pefa_pkg;

  localparam logic [4:0] TypeSyn = 5'd0;
  localparam logic [4:0] TypeKey = 5'd1;
  localparam logic [4:0] TypeRel = 5'd2;
  localparam logic [4:0] TypeAbs = 5'd3;

  localparam logic [9:0] CodeX        = 10'd0;
  localparam logic [9:0] CodeY        = 10'd1;
  localparam logic [9:0] CodePressure = 10'd24;
  localparam logic [9:0] CodeLeft     = 10'd272;
  localparam logic [9:0] CodeRight    = 10'd273;
  localparam logic [9:0] CodeMiddle   = 10'd274;
  localparam logic [9:0] CodeReport   = 10'd0;

  localparam logic [2:0] FlagMotion   = 3'h1;
  localparam logic [2:0] FlagButton   = 3'h2;
  localparam logic [2:0] FlagPressure = 3'h4;

  localparam logic [30:0] DefaultPressureMax = 31'd1023;
  localparam logic [31:0] UsecPerSec         = 32'd1000000;

  // Command queue depth and pointer width.
  localparam int QDepth = 2;
  localparam int QPtrW  = 1;
  localparam int QCntW  = 2;

  // Pressure quotient width: one quotient bit per divider step.
  localparam int DivSteps = 16;
  localparam int DivCntW  = 4;

  typedef enum logic [2:0] {
    OP_REL_X,
    OP_REL_Y,
    OP_ABS_X,
    OP_ABS_Y,
    OP_PRESS,
    OP_KEY,
    OP_SYNC
  } op_t;

  typedef struct packed {
    op_t         op;
    logic        resync;
    logic [31:0] fixed;       // 24.8 value for motion commands
    logic [30:0] pnum_hi;     // pressure numerator, upper 31 bits
    logic [15:0] pnum_lo;     // pressure numerator, lower 16 bits
    logic [2:0]  key_mask;
    logic        key_pressed;
    logic [31:0] time_prod;   // seconds times one million, low 32 bits
    logic [19:0] usec;
  } cmd_t;

  // A programmed maximum of zero selects the default.
  function automatic logic [30:0] eff_pmax(input logic [30:0] cfg);
    eff_pmax = (cfg == 31'd0) ? DefaultPressureMax : cfg;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/pefa_if.sv @@
// Channel interfaces of the pointer event frame assembler: input events
// and output samples, each with valid/ready. No dependencies.
`default_nettype none

interface pefa_event_if;
  logic               valid;
  logic               ready;
  logic        [4:0]  event_type;
  logic        [9:0]  event_code;
  logic signed [31:0] event_value;
  logic        [31:0] time_seconds;
  logic        [19:0] time_microseconds;
  logic               resync_mode;

  modport source (output valid, event_type, event_code, event_value, time_seconds,
                  time_microseconds, resync_mode, input ready);
  modport sink (input valid, event_type, event_code, event_value, time_seconds,
                time_microseconds, resync_mode, output ready);
endinterface

interface pefa_sample_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample_dx;
  logic signed [31:0] sample_dy;
  logic        [15:0] sample_pressure;
  logic        [2:0]  sample_buttons;
  logic        [31:0] sample_time;

  modport source (output valid, sample_dx, sample_dy, sample_pressure, sample_buttons,
                  sample_time, input ready);
  modport sink (input valid, sample_dx, sample_dy, sample_pressure, sample_buttons,
                sample_time, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/pefa_front.sv @@
// Front end: accepts input events, classifies them into commands and
// pushes them into the command queue. Depends on pefa_pkg, pefa_if.
`default_nettype none

module pefa_front (
  pefa_event_if.sink        events,
  input  wire logic [30:0]  pmax,
  input  wire logic         full,
  output logic              push,
  output pefa_pkg::cmd_t    cmd
);
  import pefa_pkg::*;

  logic        keep;
  logic [31:0] abs_fixed;
  logic [31:0] rel_fixed;
  logic [30:0] pclamp;
  logic [46:0] pnum;
  logic [2:0]  mask;
  logic        is_x;
  logic        is_y;
  logic        is_p;

  assign is_x = (events.event_code == CodeX);
  assign is_y = (events.event_code == CodeY);
  assign is_p = (events.event_code == CodePressure);

  // Absolute coordinate times 256, saturated to the signed 32-bit range.
  always_comb begin
    if (events.event_value[31:23] == 9'h000 || events.event_value[31:23] == 9'h1FF) begin
      abs_fixed = {events.event_value[23:0], 8'h00};
    end else if (events.event_value[31]) begin
      abs_fixed = 32'h8000_0000;
    end else begin
      abs_fixed = 32'h7FFF_FFFF;
    end
  end

  assign rel_fixed = {events.event_value[23:0], 8'h00};

  // Clamp pressure to [0, max], then form value * 65535.
  always_comb begin
    if (events.event_value[31]) begin
      pclamp = 31'd0;
    end else if (events.event_value[30:0] > pmax) begin
      pclamp = pmax;
    end else begin
      pclamp = events.event_value[30:0];
    end
  end

  assign pnum = {pclamp, 16'h0000} - {16'h0000, pclamp};

  always_comb begin
    case (events.event_code)
      CodeLeft:   mask = 3'b001;
      CodeRight:  mask = 3'b010;
      CodeMiddle: mask = 3'b100;
      default:    mask = 3'b000;
    endcase
  end

  always_comb begin
    keep            = 1'b0;
    cmd.op          = OP_SYNC;
    cmd.resync      = events.resync_mode;
    cmd.fixed       = (events.event_type == TypeRel) ? rel_fixed : abs_fixed;
    cmd.pnum_hi     = pnum[46:16];
    cmd.pnum_lo     = pnum[15:0];
    cmd.key_mask    = mask;
    cmd.key_pressed = (events.event_value != 32'sd0);
    cmd.time_prod   = events.time_seconds * UsecPerSec;
    cmd.usec        = events.time_microseconds;
    case (events.event_type)
      TypeRel: begin
        if (!events.resync_mode && is_x) begin
          keep = 1'b1; cmd.op = OP_REL_X;
        end else if (!events.resync_mode && is_y) begin
          keep = 1'b1; cmd.op = OP_REL_Y;
        end
      end
      TypeAbs: begin
        if (is_x) begin
          keep = 1'b1; cmd.op = OP_ABS_X;
        end else if (is_y) begin
          keep = 1'b1; cmd.op = OP_ABS_Y;
        end else if (is_p) begin
          keep = 1'b1; cmd.op = OP_PRESS;
        end
      end
      TypeKey: begin
        if (mask != 3'b000) begin
          keep = 1'b1; cmd.op = OP_KEY;
        end
      end
      TypeSyn: begin
        if (!events.resync_mode && events.event_code == CodeReport) begin
          keep = 1'b1; cmd.op = OP_SYNC;
        end
      end
      default: keep = 1'b0;
    endcase
  end

  // Ignored events are taken and dropped here.
  assign events.ready = !full;
  assign push         = events.valid && !full && keep;

endmodule

`default_nettype wire

@@ hw/rtl/pefa_queue.sv @@
// Short command queue between the front and back ends.
// Depends on pefa_pkg.
`default_nettype none

module pefa_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  pefa_pkg::cmd_t      wr_cmd,
  output logic                full,
  output logic                valid,
  output pefa_pkg::cmd_t      head,
  input  wire logic           pop
);
  import pefa_pkg::*;

  cmd_t             entries [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] count;

  assign full  = (count == QCntW'(QDepth));
  assign valid = (count != '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= wr_cmd;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("command pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> valid)
    else $error("command popped from an empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
                                  count <= QCntW'(QDepth))
    else $error("queue count out of range");

endmodule

`default_nettype wire

@@ hw/rtl/pefa_back.sv @@
// Back end: executes queued commands against the frame state, scales
// pressure with a bit-serial divider and holds the output sample register.
// Depends on pefa_pkg, pefa_if.
`default_nettype none

module pefa_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [30:0]   pmax,
  input  wire logic          q_valid,
  input  pefa_pkg::cmd_t     head,
  output logic               pop,
  pefa_sample_if.source      samples
);
  import pefa_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DIV  = 2'b10
  } state_t;

  state_t             state;
  logic [DivCntW-1:0] div_cnt;
  logic [30:0]        rem;
  logic [15:0]        quo;
  logic               div_resync;

  logic [31:0] accum_x;
  logic [31:0] accum_y;
  logic [15:0] accum_pressure;
  logic [2:0]  flags;
  logic [31:0] mirror_x;
  logic [31:0] mirror_y;
  logic [15:0] mirror_pressure;
  logic [2:0]  held_buttons;

  logic        out_free;
  logic        emit;
  logic [31:0] trial;
  logic        ge;
  logic [30:0] rem_next;
  logic [15:0] quo_next;

  assign out_free = !samples.valid || samples.ready;
  // A sync waits until the output register can take a sample.
  assign pop  = (state == ST_IDLE) && q_valid && ((head.op != OP_SYNC) || out_free);
  assign emit = pop && (head.op == OP_SYNC) && (flags != 3'b000);

  // One restoring-division step per cycle.
  assign trial    = {rem, quo[15]};
  assign ge       = (trial >= {1'b0, pmax});
  assign rem_next = ge ? 31'(trial - {1'b0, pmax}) : trial[30:0];
  assign quo_next = {quo[14:0], ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      div_cnt         <= '0;
      accum_x         <= '0;
      accum_y         <= '0;
      accum_pressure  <= '0;
      flags           <= '0;
      mirror_x        <= '0;
      mirror_y        <= '0;
      mirror_pressure <= '0;
      held_buttons    <= '0;
      samples.valid   <= 1'b0;
    end else begin
      if (emit) begin
        samples.valid <= 1'b1;
      end else if (samples.ready) begin
        samples.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pop) begin
            case (head.op)
              OP_REL_X: begin
                accum_x <= accum_x + head.fixed;
                flags   <= flags | FlagMotion;
              end
              OP_REL_Y: begin
                accum_y <= accum_y + head.fixed;
                flags   <= flags | FlagMotion;
              end
              OP_ABS_X: begin
                mirror_x <= head.fixed;
                if (!head.resync) begin
                  accum_x <= head.fixed;
                  flags   <= flags | FlagMotion;
                end
              end
              OP_ABS_Y: begin
                mirror_y <= head.fixed;
                if (!head.resync) begin
                  accum_y <= head.fixed;
                  flags   <= flags | FlagMotion;
                end
              end
              OP_PRESS: begin
                state   <= ST_DIV;
                div_cnt <= '0;
              end
              OP_KEY: begin
                if (head.key_pressed) begin
                  held_buttons <= held_buttons | head.key_mask;
                end else begin
                  held_buttons <= held_buttons & ~head.key_mask;
                end
                if (!head.resync) flags <= flags | FlagButton;
              end
              OP_SYNC: begin
                if (emit) begin
                  accum_x        <= '0;
                  accum_y        <= '0;
                  accum_pressure <= '0;
                  flags          <= '0;
                end
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_DIV: begin
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DivCntW'(DivSteps - 1)) begin
            state           <= ST_IDLE;
            mirror_pressure <= quo_next;
            if (!div_resync) begin
              accum_pressure <= quo_next;
              flags          <= flags | FlagPressure;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Divider datapath and output payload carry no reset.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      rem        <= head.pnum_hi;
      quo        <= head.pnum_lo;
      div_resync <= head.resync;
    end else begin
      rem <= rem_next;
      quo <= quo_next;
    end
    if (emit) begin
      if ((flags & FlagMotion) == 3'b000) begin
        samples.sample_dx       <= mirror_x;
        samples.sample_dy       <= mirror_y;
        samples.sample_pressure <= mirror_pressure;
      end else begin
        samples.sample_dx       <= accum_x;
        samples.sample_dy       <= accum_y;
        samples.sample_pressure <= accum_pressure;
      end
      samples.sample_buttons <= held_buttons;
      samples.sample_time    <= head.time_prod + {12'h000, head.usec};
    end
  end

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
                                    pop |-> state == ST_IDLE)
    else $error("command popped while the divider is busy");
  a_press_starts_div: assert property (@(posedge clk) disable iff (rst)
                                       (pop && head.op == OP_PRESS) |=> state == ST_DIV)
    else $error("pressure command did not start the divider");
  a_sample_from_sync: assert property (@(posedge clk) disable iff (rst)
                                       $rose(samples.valid) |-> $past(emit))
    else $error("sample raised without a report sync");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
                                   emit |-> out_free)
    else $error("sample register overwritten before it was taken");

endmodule

`default_nettype wire

@@ hw/rtl/pointer_event_frame_assembler_top.sv @@
// Top level of the pointer event frame assembler: configuration register,
// front end, command queue and back end. Depends on pefa_pkg, pefa_if,
// pefa_front, pefa_queue, pefa_back.
//
//   Channel                 Direction  Handshake          Carries
//   events                  in         valid/ready        one input event
//   samples                 out        valid/ready        one assembled sample
//   pressure_maximum_we/_wd in         write enable only  pressure maximum
//
// The front end takes one event per cycle whenever the two-entry command
// queue has room, so events are accepted back to back in bursts.
// The back end executes one command per cycle while it is idle, and a report
// sync only when the output register is free; an absolute pressure event keeps
// it busy while its 16-bit scaled value comes from a bit-serial divider that
// produces one quotient bit per cycle. A sample is presented in the cycle
// after the back end takes its report sync from the queue.
// Reset (rst, synchronous, active high) clears the frame state, mirrors,
// held buttons, the pressure maximum and the queue. A stalled output holds a
// report sync at the head of the queue; the commands behind it wait, and
// events keep being accepted until the queue is full.
`default_nettype none

module pointer_event_frame_assembler_top (
  input  wire logic        clk,
  input  wire logic        rst,
  pefa_event_if.sink       events,
  pefa_sample_if.source    samples,
  input  wire logic        pressure_maximum_we,
  input  wire logic [30:0] pressure_maximum_wd
);
  import pefa_pkg::*;

  logic [30:0] pressure_maximum;
  logic [30:0] pmax;
  logic        push;
  logic        full;
  logic        q_valid;
  logic        pop;
  cmd_t        wr_cmd;
  cmd_t        head;

  // Configuration must be written only while the block is idle (the block does
  // not enforce this), so both ends may use the register directly.
  always_ff @(posedge clk) begin
    if (rst) begin
      pressure_maximum <= '0;
    end else if (pressure_maximum_we) begin
      pressure_maximum <= pressure_maximum_wd;
    end
  end

  // Zero in the register means the default maximum of 1023.
  assign pmax = eff_pmax(pressure_maximum);

  pefa_front u_front (
    .events (events),
    .pmax   (pmax),
    .full   (full),
    .push   (push),
    .cmd    (wr_cmd)
  );

  pefa_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_cmd (wr_cmd),
    .full   (full),
    .valid  (q_valid),
    .head   (head),
    .pop    (pop)
  );

  pefa_back u_back (
    .clk     (clk),
    .rst     (rst),
    .pmax    (pmax),
    .q_valid (q_valid),
    .head    (head),
    .pop     (pop),
    .samples (samples)
  );

endmodule

`default_nettype wire
